>>> sv/best_fit_segment_allocator_defines.svh
// assertion macros for the segment allocator checker
`ifndef BEST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BFSA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bfsa_pkg.sv
// shared constants for the segment allocator
package bfsa_pkg;
    localparam int unsigned ADDR_W  = 13;
    localparam int unsigned START_W = 12;
    localparam int unsigned OWNER_W = 8;

    localparam logic [1:0] ST_ALLOC    = 2'd0;
    localparam logic [1:0] ST_NOROOM   = 2'd1;
    localparam logic [1:0] ST_FREED    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [ADDR_W-1:0] LIMIT_RESET = 13'd2048;
endpackage

>>> sv/bfsa_seg_ram.sv
// segment table memory, one write and one registered read port
module bfsa_seg_ram #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned WIDTH = 35
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/best_fit_segment_allocator.sv
// best-fit segment allocator top level
// Usage:
//   requests enter on the slave stream: tuser is the command (0 allocate,
//   1 free), tdata holds owner_id and request_size. One result per request
//   leaves on the master stream: tuser is the status, tdata the segment start.
//   The limit register is written through i_cfg_wr_en / i_cfg_wr_data; the user must
//   do so only while idle, the block itself does not enforce it.
// Operation (one request at a time):
//   allocate scans the table, or shifts it up for the front gap. Free scans
//   up to the owner's position, then moves entries down after a merge, and
//   scans the whole table when the owner is missing. Allocate of size zero,
//   or any request to an empty table, finishes without a table scan.
// Reset:
//   synchronous reset empties the table (count zero), sets the limit to 2048
//   and drops any pending result; no clearing pass is needed.
// Stall:
//   a finished result waits in the output register; a following request is
//   accepted meanwhile and its result is held until the first one transfers.
module best_fit_segment_allocator #(
    parameter int unsigned MAX_SEGMENTS = 32,
    parameter int unsigned OWNER_BITS   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // owner_id [7:0], request_size [20:8], zero [23:21]
    input  logic        i_s_tuser,   // command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // segment_start [11:0], zero [15:12]
    output logic [1:0]  o_m_tuser,   // status
    input  logic        i_cfg_wr_en,
    input  logic [12:0] i_cfg_wr_data
);
    localparam int unsigned AW = $clog2(MAX_SEGMENTS);
    localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
    localparam int unsigned DW = bfsa_pkg::ADDR_W;
    localparam int unsigned EW = 2 * DW + OWNER_BITS + 1;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RD0     = 4'd1;
    localparam logic [3:0] S_ACHK    = 4'd2;
    localparam logic [3:0] S_AFIN    = 4'd3;
    localparam logic [3:0] S_SHUP    = 4'd4;
    localparam logic [3:0] S_INS0    = 4'd5;
    localparam logic [3:0] S_FCHK    = 4'd6;
    localparam logic [3:0] S_FNXT    = 4'd7;
    localparam logic [3:0] S_FMRG    = 4'd8;
    localparam logic [3:0] S_SHDN    = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0]            r_state, n_state;
    logic [DW-1:0]         r_limit;
    logic                  r_cmd;
    logic [OWNER_BITS-1:0] r_owner;
    logic [DW-1:0]         r_size;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_idx, n_idx;
    logic                  r_found, n_found;
    logic [AW-1:0]         r_best_idx, n_best_idx;
    logic [DW-1:0]         r_best_start, n_best_start;
    logic [DW-1:0]         r_best_end, n_best_end;
    logic [DW-1:0]         r_best_slack, n_best_slack;
    logic [DW-1:0]         r_tail, n_tail;
    logic                  r_prv_hole, n_prv_hole;
    logic [DW-1:0]         r_prv_start, n_prv_start;
    logic [DW-1:0]         r_cur_start, n_cur_start;
    logic [DW-1:0]         r_cur_end, n_cur_end;
    logic                  r_nxt_hole, n_nxt_hole;
    logic [DW-1:0]         r_nxt_end, n_nxt_end;
    logic [AW-1:0]         r_hit, n_hit;
    logic [AW-1:0]         r_src, n_src;
    logic [1:0]            r_dist, n_dist;
    logic [1:0]            r_res_status, n_res_status;
    logic [DW-1:0]         r_res_start, n_res_start;
    logic                  r_out_valid;
    logic [1:0]            r_out_status;
    logic [DW-1:0]         r_out_start;

    logic                  w_we, w_re;
    logic [AW-1:0]         w_waddr, w_raddr;
    logic [EW-1:0]         w_wdata, w_rdata;
    logic [DW-1:0]         w_rd_start, w_rd_end, w_len;
    logic [OWNER_BITS-1:0] w_rd_owner, w_in_owner;
    logic [OWNER_BITS+7:0] w_own_ext;
    logic                  w_rd_hole, w_room, w_last, w_fit;
    logic [DW:0]           w_app_end;
    logic [AW-1:0]         w_lo, w_hi;
    logic [DW-1:0]         w_mstart, w_mend;
    logic                  w_in_acc;

    assign w_own_ext  = {{OWNER_BITS{1'b0}}, i_s_tdata[7:0]};
    assign w_in_owner = w_own_ext[OWNER_BITS-1:0];
    assign w_rd_start = w_rdata[DW-1:0];
    assign w_rd_end   = w_rdata[2*DW-1:DW];
    assign w_rd_owner = w_rdata[2*DW+OWNER_BITS-1:2*DW];
    assign w_rd_hole  = w_rdata[EW-1];
    assign w_len      = w_rd_end - w_rd_start;
    assign w_room     = r_count < CW'(MAX_SEGMENTS);
    assign w_last     = CW'(r_idx) == r_count - CW'(1);
    assign w_fit      = w_rd_hole && (w_len >= r_size)
                        && (!r_found || ((w_len - r_size) < r_best_slack));
    assign w_app_end  = {1'b0, r_tail} + {1'b0, r_size};
    assign w_lo       = r_prv_hole ? r_hit - AW'(1) : r_hit;
    assign w_hi       = r_nxt_hole ? r_hit + AW'(1) : r_hit;
    assign w_mstart   = r_prv_hole ? r_prv_start : r_cur_start;
    assign w_mend     = r_nxt_hole ? r_nxt_end : r_cur_end;
    assign w_in_acc   = i_s_tvalid && (r_state == S_IDLE);

    bfsa_seg_ram #(
        .DEPTH (MAX_SEGMENTS),
        .WIDTH (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_found      = r_found;
        n_best_idx   = r_best_idx;
        n_best_start = r_best_start;
        n_best_end   = r_best_end;
        n_best_slack = r_best_slack;
        n_tail       = r_tail;
        n_prv_hole   = r_prv_hole;
        n_prv_start  = r_prv_start;
        n_cur_start  = r_cur_start;
        n_cur_end    = r_cur_end;
        n_nxt_hole   = r_nxt_hole;
        n_nxt_end    = r_nxt_end;
        n_hit        = r_hit;
        n_src        = r_src;
        n_dist       = r_dist;
        n_res_status = r_res_status;
        n_res_start  = r_res_start;
        w_we         = 1'b0;
        w_waddr      = '0;
        w_wdata      = '0;
        w_re         = 1'b0;
        w_raddr      = '0;
        case (r_state)
            S_IDLE: begin
                n_found     = 1'b0;
                n_prv_hole  = 1'b0;
                n_idx       = '0;
                n_res_start = '0;
                if (w_in_acc) begin
                    if (i_s_tuser == bfsa_pkg::CMD_ALLOC) begin
                        if (i_s_tdata[20:8] == '0) begin
                            n_res_status = bfsa_pkg::ST_NOROOM;
                            n_state      = S_DONE;
                        end else if (r_count == '0) begin
                            w_we         = 1'b1;
                            w_wdata      = {1'b0, w_in_owner, i_s_tdata[20:8], {DW{1'b0}}};
                            n_count      = CW'(1);
                            n_res_status = bfsa_pkg::ST_ALLOC;
                            n_state      = S_DONE;
                        end else begin
                            w_re    = 1'b1;
                            n_state = S_RD0;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res_status = bfsa_pkg::ST_NOTFOUND;
                            n_state      = S_DONE;
                        end else begin
                            w_re    = 1'b1;
                            n_state = S_FCHK;
                        end
                    end
                end
            end
            S_RD0: begin
                if (w_room && (w_rd_start != '0) && (r_size <= w_rd_start)) begin
                    n_best_end = w_rd_start;
                    w_re       = 1'b1;
                    w_raddr    = AW'(r_count - CW'(1));
                    n_src      = AW'(r_count - CW'(1));
                    n_state    = S_SHUP;
                end else begin
                    n_state = S_ACHK;
                end
            end
            S_ACHK: begin
                if (w_fit) begin
                    n_found      = 1'b1;
                    n_best_idx   = r_idx;
                    n_best_start = w_rd_start;
                    n_best_end   = w_rd_end;
                    n_best_slack = w_len - r_size;
                end
                if (w_last) begin
                    n_tail  = w_rd_end;
                    n_state = S_AFIN;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_idx + AW'(1);
                    n_idx   = r_idx + AW'(1);
                end
            end
            S_AFIN: begin
                n_state = S_DONE;
                if (r_found) begin
                    w_we         = 1'b1;
                    w_waddr      = r_best_idx;
                    w_wdata      = {1'b0, r_owner, r_best_end, r_best_start};
                    n_res_status = bfsa_pkg::ST_ALLOC;
                    n_res_start  = r_best_start;
                end else if (w_room && (w_app_end <= {1'b0, r_limit})) begin
                    w_we         = 1'b1;
                    w_waddr      = AW'(r_count);
                    w_wdata      = {1'b0, r_owner, w_app_end[DW-1:0], r_tail};
                    n_count      = r_count + CW'(1);
                    n_res_status = bfsa_pkg::ST_ALLOC;
                    n_res_start  = r_tail;
                end else begin
                    n_res_status = bfsa_pkg::ST_NOROOM;
                end
            end
            S_SHUP: begin
                w_we    = 1'b1;
                w_waddr = r_src + AW'(1);
                w_wdata = w_rdata;
                if (r_src == '0) begin
                    n_state = S_INS0;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_src - AW'(1);
                    n_src   = r_src - AW'(1);
                end
            end
            S_INS0: begin
                w_we         = 1'b1;
                w_wdata      = {1'b0, r_owner, r_best_end, {DW{1'b0}}};
                n_count      = r_count + CW'(1);
                n_res_status = bfsa_pkg::ST_ALLOC;
                n_state      = S_DONE;
            end
            S_FCHK: begin
                if (!w_rd_hole && (w_rd_owner == r_owner)) begin
                    n_hit       = r_idx;
                    n_cur_start = w_rd_start;
                    n_cur_end   = w_rd_end;
                    n_nxt_hole  = 1'b0;
                    if (w_last) begin
                        n_state = S_FMRG;
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = r_idx + AW'(1);
                        n_state = S_FNXT;
                    end
                end else begin
                    n_prv_hole  = w_rd_hole;
                    n_prv_start = w_rd_start;
                    if (w_last) begin
                        n_res_status = bfsa_pkg::ST_NOTFOUND;
                        n_state      = S_DONE;
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = r_idx + AW'(1);
                        n_idx   = r_idx + AW'(1);
                    end
                end
            end
            S_FNXT: begin
                n_nxt_hole = w_rd_hole;
                n_nxt_end  = w_rd_end;
                n_state    = S_FMRG;
            end
            S_FMRG: begin
                n_res_status = bfsa_pkg::ST_FREED;
                n_src        = w_hi + AW'(1);
                if (CW'(w_hi) == r_count - CW'(1)) begin
                    n_count = CW'(w_lo);
                    n_state = S_DONE;
                end else if (w_lo == '0) begin
                    n_dist  = 2'(w_hi + AW'(1));
                    w_re    = 1'b1;
                    w_raddr = w_hi + AW'(1);
                    n_state = S_SHDN;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = w_lo;
                    w_wdata = {1'b1, {OWNER_BITS{1'b0}}, w_mend, w_mstart};
                    n_dist  = 2'(w_hi - w_lo);
                    if (w_hi == w_lo) begin
                        n_state = S_DONE;
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = w_hi + AW'(1);
                        n_state = S_SHDN;
                    end
                end
            end
            S_SHDN: begin
                w_we    = 1'b1;
                w_waddr = r_src - AW'(r_dist);
                w_wdata = w_rdata;
                if (CW'(r_src) == r_count - CW'(1)) begin
                    n_count = r_count - CW'(r_dist);
                    n_state = S_DONE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_src + AW'(1);
                    n_src   = r_src + AW'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_limit     <= bfsa_pkg::LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (r_state == S_DONE && (!r_out_valid || i_m_tready)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd   <= i_s_tuser;
            r_owner <= w_in_owner;
            r_size  <= i_s_tdata[20:8];
        end
        if (r_state == S_DONE && (!r_out_valid || i_m_tready)) begin
            r_out_status <= r_res_status;
            r_out_start  <= (r_cmd == bfsa_pkg::CMD_ALLOC) ? r_res_start : '0;
        end
        r_idx        <= n_idx;
        r_found      <= n_found;
        r_best_idx   <= n_best_idx;
        r_best_start <= n_best_start;
        r_best_end   <= n_best_end;
        r_best_slack <= n_best_slack;
        r_tail       <= n_tail;
        r_prv_hole   <= n_prv_hole;
        r_prv_start  <= n_prv_start;
        r_cur_start  <= n_cur_start;
        r_cur_end    <= n_cur_end;
        r_nxt_hole   <= n_nxt_hole;
        r_nxt_end    <= n_nxt_end;
        r_hit        <= n_hit;
        r_src        <= n_src;
        r_dist       <= n_dist;
        r_res_status <= n_res_status;
        r_res_start  <= n_res_start;
    end

    assign o_s_tready = r_state == S_IDLE;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {4'b0000, r_out_start[bfsa_pkg::START_W-1:0]};
endmodule

>>> sv/bfsa_checker.sv
// port-level checker for the segment allocator, bound to the top level
`include "best_fit_segment_allocator_defines.svh"

module bfsa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);
    `BFSA_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid, "result dropped while stalled")
    `BFSA_ASSERT_NEXT(a_busy_after_in, i_s_tvalid && o_s_tready, !o_s_tready, "ready right after transfer")
    `BFSA_ASSERT_NOW(a_start_zero, o_m_tvalid && (o_m_tuser != bfsa_pkg::ST_ALLOC), o_m_tdata == 16'd0, "start not zero")
    `BFSA_ASSERT_NOW(a_pad_zero, o_m_tvalid, o_m_tdata[15:12] == 4'd0, "padding bits set")
endmodule

bind best_fit_segment_allocator bfsa_checker u_bfsa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
